[hw/rtl/multi_party_set_intersection_table_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-party set intersection table
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_PARTY_SET_INTERSECTION_TABLE_MACROS_SVH
`define MULTI_PARTY_SET_INTERSECTION_TABLE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MPSIT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MPSIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mpsit_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-party set intersection table package
// Sizes, operation codes, hash constants and the request type.
// ----------------------------------------------------------------------------
package mpsit_pkg;

  localparam int MAX_PARTIES   = 8;
  localparam int TABLE_ENTRIES = 4096;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int PARTY_W       = $clog2(MAX_PARTIES);
  localparam int POS_W         = 16;
  localparam int WORD_W        = 64;
  localparam int ROUND_W       = 4;
  localparam int COUNT_W       = 13;
  localparam int PC_W          = 4;
  localparam int HALF_W        = 22;
  localparam int HASH_W        = 2 * HALF_W;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [WORD_W-1:0] HASH_MULT = 64'h9E3779B97F4A7C15;
  localparam logic [HALF_W-1:0] HASH_C0   = HASH_MULT[HALF_W-1:0];
  localparam logic [HALF_W-1:0] HASH_C1   = HASH_MULT[HASH_W-1:HALF_W];

  typedef struct packed {
    logic [1:0]         opcode;
    logic [PARTY_W-1:0] party;
    logic [POS_W-1:0]   position;
    logic [WORD_W-1:0]  key_word;
    logic [WORD_W-1:0]  tag_word;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  home;
  } req_t;

endpackage

[hw/rtl/mpsit_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts requests and computes the home slot of the key in two stages.
// ----------------------------------------------------------------------------
module mpsit_front import mpsit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [PARTY_W-1:0] party,
  input  logic [POS_W-1:0]   position,
  input  logic [WORD_W-1:0]  key_word,
  input  logic [WORD_W-1:0]  tag_word,
  input  logic [SLOT_W-1:0]  slot,
  output logic               push_valid,
  output req_t               push_req,
  input  logic               push_ready
);

  logic              s1_valid;
  req_t              s1_req;
  req_t              s1_hashed;
  logic [HASH_W-1:0] s1_p00;
  logic [HALF_W-1:0] s1_p01;
  logic [HALF_W-1:0] s1_p10;
  logic              s2_valid;
  req_t              s2_req;
  logic              s1_move;
  logic              s2_free;
  logic [HASH_W-1:0] hash_sum;
  logic [HALF_W-1:0] cross_sum;
  logic [HASH_W-1:0] p01_full;
  logic [HASH_W-1:0] p10_full;

  assign s2_free    = !s2_valid || push_ready;
  assign s1_move    = s1_valid && s2_free;
  assign in_ready   = !s1_valid || s1_move;
  assign push_valid = s2_valid;
  assign push_req   = s2_req;

  assign p01_full  = key_word[HALF_W-1:0] * HASH_C1;
  assign p10_full  = key_word[HASH_W-1:HALF_W] * HASH_C0;
  assign cross_sum = s1_p01 + s1_p10;
  assign hash_sum  = s1_p00 + {cross_sum, {HALF_W{1'b0}}};

  always_comb begin
    s1_hashed      = s1_req;
    s1_hashed.home = hash_sum[SLOT_W-1:0] ^ hash_sum[HASH_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
    if (in_ready && in_valid) begin
      s1_req.opcode   <= opcode;
      s1_req.party    <= party;
      s1_req.position <= position;
      s1_req.key_word <= key_word;
      s1_req.tag_word <= tag_word;
      s1_req.slot     <= slot;
      s1_req.home     <= '0;
      s1_p00          <= key_word[HALF_W-1:0] * HASH_C0;
      s1_p01          <= p01_full[HALF_W-1:0];
      s1_p10          <= p10_full[HALF_W-1:0];
    end
    if (s1_move) begin
      s2_req <= s1_hashed;
    end
  end

endmodule

[hw/rtl/mpsit_queue.sv]
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module mpsit_queue import mpsit_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  req_t push_req,
  output logic push_ready,
  output logic pop_valid,
  output req_t pop_req,
  input  logic pop
);

  req_t       entries [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !pop) begin
        fill <= fill + 2'd1;
      end else if (!do_push && pop) begin
        fill <= fill - 2'd1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

[hw/rtl/mpsit_back.sv]
// ----------------------------------------------------------------------------
// Table engine
// Probes the hash table, updates entries and round counts, answers reads and clears.
// ----------------------------------------------------------------------------
`include "multi_party_set_intersection_table_macros.svh"

module mpsit_back import mpsit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [PC_W-1:0]    party_count,
  input  logic               q_valid,
  input  req_t               q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               matched,
  output logic               in_result,
  output logic [POS_W-1:0]   party_position,
  output logic [COUNT_W-1:0] result_count,
  output logic               status
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE,
    ST_EVAL,
    ST_FINISH
  } state_t;

  state_t state;

  logic [WORD_W-1:0]  key_mem   [0:TABLE_ENTRIES-1];
  logic [WORD_W-1:0]  tag_mem   [0:TABLE_ENTRIES-1];
  logic [ROUND_W-1:0] round_mem [0:TABLE_ENTRIES-1];
  logic [POS_W-1:0]   pos_mem   [0:TABLE_ENTRIES*MAX_PARTIES-1];

  logic [COUNT_W-1:0] hist [0:MAX_PARTIES-1];

  req_t               cur;
  logic [SLOT_W-1:0]  probe_idx;
  logic [SLOT_W-1:0]  probe_cnt;
  logic [SLOT_W-1:0]  sweep_ctr;
  logic               res_matched;
  logic               res_in;
  logic [POS_W-1:0]   res_pos;
  logic               res_status;

  logic [WORD_W-1:0]  rd_key;
  logic [WORD_W-1:0]  rd_tag;
  logic [ROUND_W-1:0] rd_round;
  logic [POS_W-1:0]   rd_pos;

  logic [ROUND_W-1:0] pc_eff;
  logic [ROUND_W-1:0] party_ext;
  logic [ROUND_W-1:0] party_inc;
  logic               is_empty;
  logic               is_key;
  logic               is_last;
  logic               can_join;
  logic [ROUND_W-1:0] join_round;

  logic               kt_we;
  logic               pos_we;
  logic               rnd_we;
  logic [SLOT_W-1:0]  rnd_waddr;
  logic [ROUND_W-1:0] rnd_wdata;
  logic               h_dec;
  logic               h_inc;
  logic [PARTY_W-1:0] h_dec_idx;
  logic [PARTY_W-1:0] h_inc_idx;
  logic               h_clear;
  logic [COUNT_W-1:0] survivors;

  always_comb begin
    if (party_count == '0) begin
      pc_eff = ROUND_W'(1);
    end else if (party_count > PC_W'(MAX_PARTIES)) begin
      pc_eff = ROUND_W'(MAX_PARTIES);
    end else begin
      pc_eff = party_count;
    end
  end

  assign party_ext  = ROUND_W'(cur.party);
  assign party_inc  = party_ext + ROUND_W'(1);
  assign is_empty   = (rd_round == '0);
  assign is_key     = !is_empty && (rd_key == cur.key_word);
  assign is_last    = &probe_cnt;
  assign can_join   = is_key && (rd_round >= party_ext) && (rd_tag == cur.tag_word);
  assign join_round = (rd_round > party_ext) ? rd_round : party_inc;
  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign h_clear    = q_pop && (q_req.opcode == OP_CLEAR);

  always_comb begin
    kt_we     = 1'b0;
    pos_we    = 1'b0;
    rnd_we    = 1'b0;
    rnd_waddr = probe_idx;
    rnd_wdata = '0;
    h_dec     = 1'b0;
    h_inc     = 1'b0;
    h_dec_idx = PARTY_W'(rd_round - ROUND_W'(1));
    h_inc_idx = '0;
    if (state == ST_SWEEP) begin
      rnd_we    = 1'b1;
      rnd_waddr = sweep_ctr;
    end else if (state == ST_EVAL && cur.opcode == OP_ADD) begin
      if (cur.party == '0) begin
        if (is_empty || is_key) begin
          kt_we     = 1'b1;
          pos_we    = 1'b1;
          rnd_we    = 1'b1;
          rnd_wdata = ROUND_W'(1);
          h_dec     = (rd_round > ROUND_W'(1));
          h_inc     = (rd_round != ROUND_W'(1));
        end
      end else if (can_join) begin
        pos_we    = 1'b1;
        rnd_we    = 1'b1;
        rnd_wdata = join_round;
        h_dec     = (join_round != rd_round);
        h_inc     = (join_round != rd_round);
        h_inc_idx = PARTY_W'(join_round - ROUND_W'(1));
      end
    end
  end

  always_comb begin
    survivors = '0;
    for (int i = 0; i < MAX_PARTIES; i++) begin
      if (ROUND_W'(i + 1) >= pc_eff) begin
        survivors = survivors + hist[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= key_mem[probe_idx];
    rd_tag   <= tag_mem[probe_idx];
    rd_round <= round_mem[probe_idx];
    rd_pos   <= pos_mem[{probe_idx, cur.party}];
    if (kt_we) begin
      key_mem[probe_idx] <= cur.key_word;
      tag_mem[probe_idx] <= cur.tag_word;
    end
    if (rnd_we) begin
      round_mem[rnd_waddr] <= rnd_wdata;
    end
    if (pos_we) begin
      pos_mem[{probe_idx, cur.party}] <= cur.position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || h_clear) begin
      for (int i = 0; i < MAX_PARTIES; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (h_dec) begin
        hist[h_dec_idx] <= hist[h_dec_idx] - COUNT_W'(1);
      end
      if (h_inc) begin
        hist[h_inc_idx] <= hist[h_inc_idx] + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_ctr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_ctr <= sweep_ctr + SLOT_W'(1);
          if (&sweep_ctr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur         <= q_req;
            probe_cnt   <= '0;
            res_matched <= 1'b0;
            res_in      <= 1'b0;
            res_pos     <= '0;
            res_status  <= 1'b0;
            if (q_req.opcode == OP_ADD) begin
              probe_idx <= q_req.home;
              state     <= ST_PROBE;
            end else if (q_req.opcode == OP_READ) begin
              probe_idx <= q_req.slot;
              state     <= ST_PROBE;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_PROBE: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (cur.opcode == OP_READ) begin
            res_in  <= (rd_round >= pc_eff);
            res_pos <= (rd_round > party_ext) ? rd_pos : '0;
            state   <= ST_FINISH;
          end else if (cur.party == '0 && (is_empty || is_key)) begin
            res_matched <= 1'b1;
            state       <= ST_FINISH;
          end else if (cur.party != '0 && (is_empty || is_key)) begin
            res_matched <= can_join;
            state       <= ST_FINISH;
          end else if (is_last) begin
            res_status <= (cur.party == '0);
            state      <= ST_FINISH;
          end else begin
            probe_idx <= probe_idx + SLOT_W'(1);
            probe_cnt <= probe_cnt + SLOT_W'(1);
            state     <= ST_PROBE;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            matched        <= res_matched;
            in_result      <= res_in;
            party_position <= res_pos;
            status         <= res_status;
            result_count   <= survivors;
            sweep_ctr      <= '0;
            state          <= (cur.opcode == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MPSIT_ASSERT_IMPLY(a_result_from_finish, $rose(out_valid), $past(state == ST_FINISH),
    "result appeared outside the finish step")
  `MPSIT_ASSERT_IMPLY(a_eval_after_probe, state == ST_EVAL, $past(state == ST_PROBE),
    "evaluation without a table read")
  `MPSIT_ASSERT_NEXT(a_read_one_probe, state == ST_EVAL && cur.opcode == OP_READ,
    state == ST_FINISH, "slot read took more than one probe")

endmodule

[hw/rtl/multi_party_set_intersection_table.sv]
// Each probe is one registered table read. An add probes successive slots from its
// home slot until it meets an empty slot or its key, or has probed every slot; a
// slot read probes only the given slot. Requests are handled one at a time.
// A clear or a reset runs a sweep of the whole round memory; no request is
// taken from the queue meanwhile, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Multi-party set intersection table
// Hash table that intersects masked elements of several parties in order.
// ----------------------------------------------------------------------------
module multi_party_set_intersection_table import mpsit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [PC_W-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [PARTY_W-1:0] party,
  input  logic [POS_W-1:0]   position,
  input  logic [WORD_W-1:0]  key_word,
  input  logic [WORD_W-1:0]  tag_word,
  input  logic [SLOT_W-1:0]  slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               matched,
  output logic               in_result,
  output logic [POS_W-1:0]   party_position,
  output logic [COUNT_W-1:0] result_count,
  output logic               status
);

  logic [PC_W-1:0] party_count;
  logic            push_valid;
  logic            push_ready;
  req_t            push_req;
  logic            q_valid;
  req_t            q_req;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      party_count <= PC_W'(2);
    end else if (cfg_we) begin
      party_count <= cfg_data;
    end
  end

  mpsit_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .party      (party),
    .position   (position),
    .key_word   (key_word),
    .tag_word   (tag_word),
    .slot       (slot),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_ready (push_ready)
  );

  mpsit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_req    (q_req),
    .pop        (q_pop)
  );

  mpsit_back u_back (
    .clk            (clk),
    .rst            (rst),
    .party_count    (party_count),
    .q_valid        (q_valid),
    .q_req          (q_req),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .matched        (matched),
    .in_result      (in_result),
    .party_position (party_position),
    .result_count   (result_count),
    .status         (status)
  );

endmodule
